>>> hdl/fnpc_pkg.sv
// Shared types, sizes and codes of the four-neighbor peak clamp.
`default_nettype none
package fnpc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int PIXEL_BITS = 16;

  localparam int ADDR_BITS  = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS = $clog2(MAX_WIDTH + 1);

  localparam int CFG_WIDTH_BITS  = 11;
  localparam int CFG_HEIGHT_BITS = 16;
  localparam int CFG_IDX_BITS    = 1;
  localparam int CFG_DATA_BITS   = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic                  command;
    logic [PIXEL_BITS-1:0] pixel_in;
  } fnpc_in_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_out;
    logic                  row_end;
    logic                  frame_end;
  } fnpc_out_t;

  // One issued item on its way into the clamp stage.
  typedef struct packed {
    logic [ADDR_BITS-1:0]  addr;
    logic [PIXEL_BITS-1:0] pixel;
    logic                  is_pix;
    logic                  res;
    logic                  up_ok;
    logic                  left_ok;
    logic                  right_ok;
    logic                  row_end;
    logic                  frame_end;
  } fnpc_issue_t;

endpackage
`default_nettype wire

>>> hdl/four_neighbor_peak_clamp.sv
// Top level of the four-neighbor peak clamp.
// Usage:
//   Pixels of a frame_width x frame_height frame enter in raster order on the
//   input channel (command = pixel). Each pixel is replaced by the smaller of
//   itself and the largest of its in-frame up, down, left and right neighbors.
//   A result for row r-1 leaves when the pixel below it enters; the first row
//   gives none. Once the whole frame is in, drain commands each release one
//   pixel of the last row; the final drain carries frame_end and starts the
//   next frame. Pixels after the frame is complete and drains before it is
//   complete are taken and dropped.
//   Configuration writes (width, height) restart the frame; issue them only
//   while no item is in flight.
//   Timing: one item per cycle unless the receiver stalls; each taken item is
//   registered in the clamp stage and its result in the output register. Two
//   line buffers each serve one row read per item (two ports on the previous
//   row), which sets the rate. When the receiver stalls, the output register
//   holds its item, the clamp stage holds one more, and then input stall rises.
//   Reset clears the counters and pipeline; width and height return to one.
//   Line buffers are not cleared: only rows written in the current frame
//   are ever read.
`default_nettype none
module four_neighbor_peak_clamp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fnpc_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [fnpc_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  fnpc_pkg::fnpc_in_t                 in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output fnpc_pkg::fnpc_out_t                out_item_o
);
  import fnpc_pkg::*;

  logic                  busy;
  logic                  issue_valid;
  fnpc_issue_t           issue;
  logic [PIXEL_BITS-1:0] centre;
  logic [PIXEL_BITS-1:0] right;
  logic [PIXEL_BITS-1:0] up;
  logic                  wr_two_en;
  logic [ADDR_BITS-1:0]  wr_two_addr;

  // Hold the input while the clamp stage cannot hand on its item.
  assign in_stall_o = busy;

  // Counters and issue: decide per item whether it acts or is dropped.
  fnpc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_item_i     (in_item_i),
    .busy_i        (busy),
    .issue_valid_o (issue_valid),
    .issue_o       (issue)
  );

  // Read the previous rows at issue; write the new pixel into row one at
  // once and the displaced row-one value into row two from the clamp stage.
  fnpc_line_mem u_mem (
    .clk_i         (clk_i),
    .rd_en_i       (issue_valid),
    .addr_i        (issue.addr),
    .wr_one_en_i   (issue_valid && issue.is_pix),
    .wr_one_data_i (issue.pixel),
    .wr_two_en_i   (wr_two_en),
    .wr_two_addr_i (wr_two_addr),
    .centre_o      (centre),
    .right_o       (right),
    .up_o          (up)
  );

  // Clamp against the neighbors and present the result.
  fnpc_clamp u_clamp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .issue_valid_i (issue_valid),
    .issue_i       (issue),
    .centre_i      (centre),
    .right_i       (right),
    .up_i          (up),
    .out_stall_i   (out_stall_i),
    .busy_o        (busy),
    .wr_two_en_o   (wr_two_en),
    .wr_two_addr_o (wr_two_addr),
    .out_valid_o   (out_valid_o),
    .out_item_o    (out_item_o)
  );

endmodule
`default_nettype wire

>>> hdl/fnpc_line_mem.sv
// Two line buffers: one write port and two read ports on the previous row.
`default_nettype none
module fnpc_line_mem (
  input  logic                            clk_i,
  input  logic                            rd_en_i,
  input  logic [fnpc_pkg::ADDR_BITS-1:0]  addr_i,
  input  logic                            wr_one_en_i,
  input  logic [fnpc_pkg::PIXEL_BITS-1:0] wr_one_data_i,
  input  logic                            wr_two_en_i,
  input  logic [fnpc_pkg::ADDR_BITS-1:0]  wr_two_addr_i,
  output logic [fnpc_pkg::PIXEL_BITS-1:0] centre_o,
  output logic [fnpc_pkg::PIXEL_BITS-1:0] right_o,
  output logic [fnpc_pkg::PIXEL_BITS-1:0] up_o
);
  import fnpc_pkg::*;

  logic [PIXEL_BITS-1:0] one_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] two_mem [MAX_WIDTH];

  logic [PIXEL_BITS-1:0] centre_q;
  logic [PIXEL_BITS-1:0] right_q;
  logic [PIXEL_BITS-1:0] up_q;
  logic [ADDR_BITS-1:0]  right_addr;

  assign right_addr = addr_i + ADDR_BITS'(1);

  // Read-first: a read at the address being written returns the old row.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      centre_q <= one_mem[addr_i];
      right_q  <= one_mem[right_addr];
      // forward the row-two write still in flight from the clamp stage
      if (wr_two_en_i && (wr_two_addr_i == addr_i)) begin
        up_q <= centre_q;
      end else begin
        up_q <= two_mem[addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_one_en_i) begin
      one_mem[addr_i] <= wr_one_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_two_en_i) begin
      two_mem[wr_two_addr_i] <= centre_q;
    end
  end

  assign centre_o = centre_q;
  assign right_o  = right_q;
  assign up_o     = up_q;

endmodule
`default_nettype wire

>>> hdl/fnpc_ctrl.sv
// Frame counters, configuration registers and item issue.
`default_nettype none
module fnpc_ctrl (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [fnpc_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [fnpc_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                 in_valid_i,
  input  fnpc_pkg::fnpc_in_t                   in_item_i,
  input  logic                                 busy_i,
  output logic                                 issue_valid_o,
  output fnpc_pkg::fnpc_issue_t                issue_o
);
  import fnpc_pkg::*;

  logic [WIDTH_BITS-1:0]      width_q,  width_d;
  logic [CFG_HEIGHT_BITS-1:0] height_q, height_d;
  logic [ADDR_BITS-1:0]       col_q,    col_d;
  logic [CFG_HEIGHT_BITS-1:0] row_q,    row_d;
  logic [ADDR_BITS-1:0]       drain_q,  drain_d;

  logic [CFG_WIDTH_BITS-1:0]  raw_width;
  logic [CFG_HEIGHT_BITS-1:0] raw_height;
  logic                       accept;
  logic                       is_pix;
  logic                       take;
  logic [ADDR_BITS-1:0]       addr;
  logic [WIDTH_BITS-1:0]      addr_next;
  logic                       last_col;

  assign raw_width  = cfg_data_i[CFG_WIDTH_BITS-1:0];
  assign raw_height = cfg_data_i[CFG_HEIGHT_BITS-1:0];

  assign accept    = in_valid_i && !busy_i;
  assign is_pix    = (in_item_i.command == CMD_PIXEL);
  assign addr      = is_pix ? col_q : drain_q;
  assign addr_next = {1'b0, addr} + WIDTH_BITS'(1);
  assign last_col  = (addr_next == width_q);

  always_comb begin
    if (is_pix) begin
      take = accept && (row_q < height_q);
    end else begin
      take = accept && (row_q >= height_q) && ({1'b0, drain_q} < width_q);
    end
  end

  always_comb begin
    issue_o.addr      = addr;
    issue_o.pixel     = in_item_i.pixel_in;
    issue_o.is_pix    = is_pix;
    issue_o.res       = is_pix ? (row_q != '0) : 1'b1;
    issue_o.up_ok     = is_pix ? (row_q >= CFG_HEIGHT_BITS'(2))
                               : (height_q >= CFG_HEIGHT_BITS'(2));
    issue_o.left_ok   = (addr != '0);
    issue_o.right_ok  = (addr_next < width_q);
    issue_o.row_end   = last_col;
    issue_o.frame_end = !is_pix && last_col;
  end

  assign issue_valid_o = take;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    drain_d  = drain_q;
    if (cfg_we_i) begin
      // any write restarts the frame
      col_d   = '0;
      row_d   = '0;
      drain_d = '0;
      case (cfg_idx_i)
        REG_FRAME_WIDTH: begin
          if (raw_width == '0) begin
            width_d = WIDTH_BITS'(1);
          end else if (32'(raw_width) > MAX_WIDTH) begin
            width_d = WIDTH_BITS'(MAX_WIDTH);
          end else begin
            width_d = WIDTH_BITS'(raw_width);
          end
        end
        REG_FRAME_HEIGHT: begin
          height_d = (raw_height == '0) ? CFG_HEIGHT_BITS'(1) : raw_height;
        end
        default: begin
        end
      endcase
    end else if (take) begin
      if (is_pix) begin
        if (last_col) begin
          col_d = '0;
          row_d = row_q + CFG_HEIGHT_BITS'(1);
        end else begin
          col_d = col_q + ADDR_BITS'(1);
        end
      end else begin
        if (last_col) begin
          col_d   = '0;
          row_d   = '0;
          drain_d = '0;
        end else begin
          drain_d = drain_q + ADDR_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_BITS'(1);
      height_q <= CFG_HEIGHT_BITS'(1);
      col_q    <= '0;
      row_q    <= '0;
      drain_q  <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      drain_q  <= drain_d;
    end
  end

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, col_q} < width_q) && ({1'b0, drain_q} < width_q))
    else $error("column or drain counter outside the row");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= height_q)
    else $error("row counter beyond frame height");

  a_frame_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && is_pix && last_col && !cfg_we_i
     && (row_q + CFG_HEIGHT_BITS'(1) == height_q))
    |=> (row_q == height_q) && (col_q == '0))
    else $error("last pixel of frame did not arm the drain");

endmodule
`default_nettype wire

>>> hdl/fnpc_clamp.sv
// Clamp stage and output register.
`default_nettype none
module fnpc_clamp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            issue_valid_i,
  input  fnpc_pkg::fnpc_issue_t           issue_i,
  input  logic [fnpc_pkg::PIXEL_BITS-1:0] centre_i,
  input  logic [fnpc_pkg::PIXEL_BITS-1:0] right_i,
  input  logic [fnpc_pkg::PIXEL_BITS-1:0] up_i,
  input  logic                            out_stall_i,
  output logic                            busy_o,
  output logic                            wr_two_en_o,
  output logic [fnpc_pkg::ADDR_BITS-1:0]  wr_two_addr_o,
  output logic                            out_valid_o,
  output fnpc_pkg::fnpc_out_t             out_item_o
);
  import fnpc_pkg::*;

  logic                  s1_valid_q;
  fnpc_issue_t           s1_q;
  logic [PIXEL_BITS-1:0] left_q;
  logic                  out_valid_q;
  fnpc_out_t             out_q;

  logic                  s1_adv;
  logic                  any;
  logic [PIXEL_BITS-1:0] up_v, down_v, left_v, right_v;
  logic [PIXEL_BITS-1:0] mx_a, mx_b, mx;
  logic [PIXEL_BITS-1:0] clamped;

  assign s1_adv = !out_valid_q || !out_stall_i;
  assign busy_o = s1_valid_q && !s1_adv;

  assign wr_two_en_o   = s1_valid_q && s1_adv && s1_q.is_pix;
  assign wr_two_addr_o = s1_q.addr;

  // Neighbors outside the frame read as zero: harmless for a max of unsigned values.
  always_comb begin
    up_v    = s1_q.up_ok    ? up_i    : '0;
    down_v  = s1_q.is_pix   ? s1_q.pixel : '0;
    left_v  = s1_q.left_ok  ? left_q  : '0;
    right_v = s1_q.right_ok ? right_i : '0;
    mx_a    = (up_v > down_v)   ? up_v   : down_v;
    mx_b    = (left_v > right_v) ? left_v : right_v;
    mx      = (mx_a > mx_b) ? mx_a : mx_b;
    any     = s1_q.up_ok || s1_q.is_pix || s1_q.left_ok || s1_q.right_ok;
    clamped = (any && (centre_i > mx)) ? mx : centre_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!busy_o) begin
        s1_valid_q <= issue_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q && s1_q.res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_o && issue_valid_i) begin
      s1_q <= issue_i;
    end
    if (s1_valid_q && s1_adv) begin
      left_q <= centre_i;
    end
    if (s1_adv && s1_valid_q && s1_q.res) begin
      out_q.pixel_out <= clamped;
      out_q.row_end   <= s1_q.row_end;
      out_q.frame_end <= s1_q.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_frame_end_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_q.frame_end || out_q.row_end))
    else $error("frame end without row end");

endmodule
`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for the four-neighbor peak clamp.
`timescale 1ns / 1ps

module tb;
  import fnpc_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int RESET_TICKS = 11;
  // Cycles to let the pipeline empty after the last expected pixel, so that any
  // dropped item has left the clamp stage and the output register as well.
  localparam int SETTLE_TICKS = 6;
  // Watchdog bound on the whole run; far more than the slowest run needs.
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_QUOTA  = 320;

  typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} step_kind_e;
  typedef enum logic [1:0] {CHK_NONE, CHK_MODEL, CHK_GIVEN} check_e;

  typedef struct packed {
    step_kind_e                kind;
    logic [CFG_IDX_BITS-1:0]   reg_idx;
    logic [CFG_DATA_BITS-1:0]  value;    // register data, or the pixel of an item
    logic                      command;
    check_e                    check;
    fnpc_out_t                 given;
  } script_row_t;

  // Directed opening: 1x1 frames, ignored commands, width and height
  // extremes, a 3x2 frame with edge pixels and a 1x3 column.
  localparam int SCRIPT_ROWS = 33;
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    // 1x1 frame after reset: no result on the pixel, pass-through on the drain
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'hFFFF, CMD_PIXEL, CHK_NONE,  '0},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'h1234, CMD_PIXEL, CHK_NONE,  '0},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'h0000, CMD_DRAIN, CHK_GIVEN, '{16'hFFFF, 1'b1, 1'b1}},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'h0000, CMD_DRAIN, CHK_NONE,  '0},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'h0000, CMD_PIXEL, CHK_NONE,  '0},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'h0000, CMD_DRAIN, CHK_GIVEN, '{16'h0000, 1'b1, 1'b1}},
    // zero width and zero height both act as one
    '{ROW_CFG,  REG_FRAME_WIDTH,  16'h0000, CMD_PIXEL, CHK_NONE,  '0},
    '{ROW_CFG,  REG_FRAME_HEIGHT, 16'h0000, CMD_PIXEL, CHK_NONE,  '0},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'hA5A5, CMD_PIXEL, CHK_NONE,  '0},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'h0000, CMD_DRAIN, CHK_GIVEN, '{16'hA5A5, 1'b1, 1'b1}},
    // 3x2 frame with an early drain and a stray pixel after completion
    '{ROW_CFG,  REG_FRAME_WIDTH,  16'h0003, CMD_PIXEL, CHK_NONE,  '0},
    '{ROW_CFG,  REG_FRAME_HEIGHT, 16'h0002, CMD_PIXEL, CHK_NONE,  '0},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'h8000, CMD_PIXEL, CHK_NONE,  '0},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'h0000, CMD_DRAIN, CHK_NONE,  '0},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'hFFFF, CMD_PIXEL, CHK_NONE,  '0},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'h0001, CMD_PIXEL, CHK_NONE,  '0},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'h7FFF, CMD_PIXEL, CHK_MODEL, '0},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'h0000, CMD_PIXEL, CHK_MODEL, '0},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'hFFFF, CMD_PIXEL, CHK_MODEL, '0},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'h4321, CMD_PIXEL, CHK_NONE,  '0},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'h0000, CMD_DRAIN, CHK_MODEL, '0},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'h0000, CMD_DRAIN, CHK_MODEL, '0},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'h0000, CMD_DRAIN, CHK_MODEL, '0},
    // all-ones width drops its upper bits and saturates; tallest height
    '{ROW_CFG,  REG_FRAME_WIDTH,  16'hFFFF, CMD_PIXEL, CHK_NONE,  '0},
    '{ROW_CFG,  REG_FRAME_HEIGHT, 16'hFFFF, CMD_PIXEL, CHK_NONE,  '0},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'h5A5A, CMD_PIXEL, CHK_NONE,  '0},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'h0F0F, CMD_PIXEL, CHK_NONE,  '0},
    // 1x3 column: only up and down neighbors count
    '{ROW_CFG,  REG_FRAME_WIDTH,  16'h0001, CMD_PIXEL, CHK_NONE,  '0},
    '{ROW_CFG,  REG_FRAME_HEIGHT, 16'h0003, CMD_PIXEL, CHK_NONE,  '0},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'h0010, CMD_PIXEL, CHK_NONE,  '0},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'h0020, CMD_PIXEL, CHK_GIVEN, '{16'h0010, 1'b1, 1'b0}},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'h0030, CMD_PIXEL, CHK_GIVEN, '{16'h0020, 1'b1, 1'b0}},
    '{ROW_ITEM, REG_FRAME_WIDTH,  16'h0000, CMD_DRAIN, CHK_GIVEN, '{16'h0020, 1'b1, 1'b1}}
  };

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  fnpc_in_t                 in_item_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  fnpc_out_t                out_item_o;

  four_neighbor_peak_clamp dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Shadow of the block: registers, line buffers, left pixel and counters.
  logic [CFG_WIDTH_BITS-1:0]  width_reg = 11'd1;
  logic [CFG_HEIGHT_BITS-1:0] height_reg = 16'd1;
  bit [PIXEL_BITS-1:0]        two_up_row [MAX_WIDTH];
  bit [PIXEL_BITS-1:0]        above_row [MAX_WIDTH];
  bit [PIXEL_BITS-1:0]        win_left;
  int unsigned                col_pos, row_pos, drain_pos;

  fnpc_out_t pending_pixels [$];
  fnpc_out_t oldest;
  int        send_idle_pct = 26;
  int        recv_stall_pct = 82;
  int        mismatches;
  int        items_sent, pixels_checked, frames_closed, cycle_count;

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (32'(width_reg) > MAX_WIDTH) return MAX_WIDTH;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned active_height();
    return (height_reg == 0) ? 1 : 32'(height_reg);
  endfunction

  // Fold one neighbor into the running peak when it lies inside the frame.
  function automatic void fold_peak(input bit in_frame, input bit [PIXEL_BITS-1:0] value,
                                    inout bit seen, inout bit [PIXEL_BITS-1:0] peak);
    if (in_frame) begin
      if (!seen || value > peak) peak = value;
      seen = 1'b1;
    end
  endfunction

  function automatic bit [PIXEL_BITS-1:0] clamp_to_peak(input bit [PIXEL_BITS-1:0] centre,
                                                       input bit seen,
                                                       input bit [PIXEL_BITS-1:0] peak);
    return (seen && centre > peak) ? peak : centre;
  endfunction

  // Advance the shadow by one accepted item; return 1 with the clamped pixel
  // when the item releases one.
  function automatic bit clamp_next(input fnpc_in_t item, output fnpc_out_t res);
    int unsigned         w, h, c, r, d;
    bit                  seen;
    bit [PIXEL_BITS-1:0] peak, centre, right;
    w = active_width();
    h = active_height();
    seen = 1'b0;
    peak = '0;
    res = '0;
    if (item.command == CMD_PIXEL) begin
      c = col_pos;
      r = row_pos;
      // drop pixels once the whole frame is in
      if (r >= h || c >= w) return 1'b0;
      centre = above_row[c];
      right = (c + 1 < w) ? above_row[c + 1] : '0;
      if (c == 0) win_left = '0;
      if (r >= 1) begin
        fold_peak(r >= 2, two_up_row[c], seen, peak);
        fold_peak(1'b1, item.pixel_in, seen, peak);
        fold_peak(c > 0, win_left, seen, peak);
        fold_peak(c + 1 < w, right, seen, peak);
        res.pixel_out = clamp_to_peak(centre, seen, peak);
        res.row_end = (c + 1 == w);
      end
      two_up_row[c] = centre;
      above_row[c] = item.pixel_in;
      win_left = centre;
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = r + 1;
      end else begin
        col_pos = c + 1;
      end
      return r >= 1;
    end
    d = drain_pos;
    // drop drains until the frame is complete
    if (row_pos < h || d >= w) return 1'b0;
    centre = above_row[d];
    fold_peak(h >= 2, two_up_row[d], seen, peak);
    fold_peak(d > 0, (d > 0) ? above_row[d - 1] : '0, seen, peak);
    fold_peak(d + 1 < w, (d + 1 < w) ? above_row[d + 1] : '0, seen, peak);
    res.pixel_out = clamp_to_peak(centre, seen, peak);
    res.row_end = (d + 1 == w);
    res.frame_end = (d + 1 == w);
    if (d + 1 >= w) begin
      col_pos = 0;
      row_pos = 0;
      drain_pos = 0;
    end else begin
      drain_pos = d + 1;
    end
    return 1'b1;
  endfunction

  function automatic logic [PIXEL_BITS-1:0] pick_pixel(input int flavor);
    case (flavor)
      0: return PIXEL_BITS'($urandom);
      1: return PIXEL_BITS'($urandom_range(3));  // many ties
      default: begin
        case ($urandom_range(3))
          0: return '0;
          1: return '1;
          2: return 16'h8000;
          default: return 16'h7FFF;
        endcase
      end
    endcase
  endfunction

  // Present one item, hold it until taken, then record what it releases.
  task automatic drive_item(input fnpc_in_t item, input check_e check, input fnpc_out_t given);
    fnpc_out_t res;
    bit        has;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_item_i = item;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    has = clamp_next(item, res);
    if (check == CHK_GIVEN) pending_pixels.push_back(given);
    else if (check == CHK_MODEL && has) pending_pixels.push_back(res);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Hold the input until every expected pixel is out and dropped items
  // have left the pipeline.
  task automatic settle();
    in_valid_i = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    settle();
    cfg_idx_i = idx;
    cfg_data_i = data;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = data[CFG_WIDTH_BITS-1:0];
    else height_reg = data[CFG_HEIGHT_BITS-1:0];
    // every write restarts the frame
    col_pos = 0;
    row_pos = 0;
    drain_pos = 0;
  endtask

  // Random frames: mostly complete raster frames plus drains, with early
  // drains, stray pixels and aborted frames mixed in.
  task automatic run_frames(input int quota);
    int                       sent, k, flavor, rows, total, stop, n;
    int unsigned              w, h;
    logic [CFG_DATA_BITS-1:0] wv, hv;
    bit                       needs_restart;
    sent = 0;
    needs_restart = 1'b1;
    while (sent < quota) begin
      if (needs_restart || $urandom_range(99) < 70) begin
        k = $urandom_range(99);
        if (k < 70) wv = CFG_DATA_BITS'($urandom_range(1, 6));
        else if (k < 92) wv = CFG_DATA_BITS'($urandom_range(7, 40));
        else wv = $urandom_range(1) ? 16'hF800 : 16'h0000;  // acts as width one
        k = $urandom_range(99);
        if (k < 65) hv = CFG_DATA_BITS'($urandom_range(1, 5));
        else if (k < 78) hv = CFG_DATA_BITS'($urandom_range(6, 12));
        else if (k < 88) hv = 16'h0000;
        else if (k < 96) hv = CFG_DATA_BITS'($urandom_range(13, 65535));
        else hv = 16'hFFFF;
        if ($urandom_range(1)) begin
          write_reg(REG_FRAME_WIDTH, wv);
          write_reg(REG_FRAME_HEIGHT, hv);
        end else begin
          write_reg(REG_FRAME_HEIGHT, hv);
          write_reg(REG_FRAME_WIDTH, wv);
        end
      end else if ($urandom_range(99) < 15) begin
        settle();
      end
      w = active_width();
      h = active_height();
      // tall frames stop after a few rows; the next write restarts them
      rows = (h > 12) ? $urandom_range(1, 4) : h;
      total = w * h + w;
      stop = (rows < h) ? w * rows : total;
      if (stop == total && $urandom_range(99) < 8) stop = $urandom_range(0, total - 1);
      flavor = $urandom_range(2);
      for (n = 0; n < stop; n++) begin
        if (n < w * h) begin
          if ($urandom_range(99) < 5)
            drive_item(fnpc_in_t'{CMD_DRAIN, pick_pixel(0)}, CHK_MODEL, '0);
          drive_item(fnpc_in_t'{CMD_PIXEL, pick_pixel(flavor)}, CHK_MODEL, '0);
        end else begin
          if (n == w * h && $urandom_range(99) < 15)
            drive_item(fnpc_in_t'{CMD_PIXEL, pick_pixel(0)}, CHK_MODEL, '0);
          drive_item(fnpc_in_t'{CMD_DRAIN, pick_pixel(0)}, CHK_MODEL, '0);
        end
      end
      needs_restart = (stop != total);
      sent += stop;
    end
  endtask

  // Receiver side: stall at random per cycle.
  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_stall_pct);
  end

  // Compare each taken pixel with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel: expected none, got %h", $time, out_item_o);
        mismatches++;
      end else begin
        oldest = pending_pixels.pop_front();
        pixels_checked++;
        if (oldest.frame_end) frames_closed++;
        if (out_item_o.pixel_out !== oldest.pixel_out) begin
          $display("%0t: pixel_out expected %h, got %h", $time, oldest.pixel_out,
                   out_item_o.pixel_out);
          mismatches++;
        end
        if (out_item_o.row_end !== oldest.row_end) begin
          $display("%0t: row_end expected %b, got %b", $time, oldest.row_end,
                   out_item_o.row_end);
          mismatches++;
        end
        if (out_item_o.frame_end !== oldest.frame_end) begin
          $display("%0t: frame_end expected %b, got %b", $time, oldest.frame_end,
                   out_item_o.frame_end);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d pixels still expected", $time, pending_pixels.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (RESET_TICKS) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Phase one: sender idles lightly, receiver stalls heavily.
    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      if (SCRIPT[i].kind == ROW_CFG)
        write_reg(SCRIPT[i].reg_idx, SCRIPT[i].value);
      else
        drive_item(fnpc_in_t'{SCRIPT[i].command, SCRIPT[i].value}, SCRIPT[i].check,
                   SCRIPT[i].given);
    end
    run_frames(PHASE_QUOTA);

    // Phase two: swap the pressure.
    send_idle_pct = 82;
    recv_stall_pct = 26;
    run_frames(PHASE_QUOTA);

    // Phase three: full rate both ways.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_frames(PHASE_QUOTA);

    settle();
    $display("Sent %0d items over a directed opening and three handshake-pressure phases;",
             items_sent);
    $display("checked %0d clamped pixels across %0d completed frames.", pixels_checked,
             frames_closed);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
